// ----- rtl/core/rfgr_pkg.sv -----
// ----------------------------------------------------------------------------
// rfgr_pkg
// Shared types and constants of the RTU frame gap receiver: sequencer
// states, CRC unit control and status, Modbus CRC-16 constants.
// ----------------------------------------------------------------------------
package rfgr_pkg;

  // input request kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // modbus crc-16, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_ZERO = 16'h0000;

  // silence counter saturation and register reset
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
  localparam logic [15:0] GAP_RESET   = 16'd35;

  // index of the last of the eight shift steps for one byte
  localparam logic [2:0] CRC_LAST_STEP = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_FETCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic       restart;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic done;
  } crc_stat_t;

  // one bit step of the reflected crc
  function automatic logic [15:0] crc_shift(input logic [15:0] c);
    logic [15:0] s;
    s = {1'b0, c[15:1]};
    if (c[0]) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/rfgr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// rfgr_crc_unit
// Bit-serial Modbus CRC-16: a byte is folded in on start, then eight shift
// steps follow, one per cycle. Holds the running crc between bytes.
// ----------------------------------------------------------------------------
module rfgr_crc_unit (
  input  logic                clk,
  input  logic                rst,
  input  rfgr_pkg::crc_ctrl_t ctrl,
  output rfgr_pkg::crc_stat_t stat,
  output logic [15:0]         crc_value
);
  import rfgr_pkg::*;

  logic [15:0] crc;
  logic [2:0]  bit_cnt;
  logic        busy;

  // load, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_INIT;
      bit_cnt <= '0;
      busy    <= 1'b0;
    end else if (ctrl.start) begin
      crc     <= (ctrl.restart ? CRC_INIT : crc) ^ {8'h00, ctrl.data};
      bit_cnt <= '0;
      busy    <= 1'b1;
    end else if (busy) begin
      crc     <= crc_shift(crc);
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == CRC_LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.done = busy && (bit_cnt == CRC_LAST_STEP);
  assign crc_value = crc;

endmodule

// ----- rtl/core/rfgr_frame_store.sv -----
// ----------------------------------------------------------------------------
// rfgr_frame_store
// Frame byte buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfgr_frame_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rtu_frame_gap_receiver.sv -----
// ----------------------------------------------------------------------------
// rtu_frame_gap_receiver
// Collects RTU bytes, checks the Modbus CRC-16 and releases good frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each request is either a received byte
// (mode 0, rx_byte) or one time tick (mode 1). A byte is stored and folded
// into the CRC by a bit-serial unit, one load and eight shift steps per byte.
// Bytes beyond FRAME_DEPTH are dropped. Ticks count silence while a frame
// is open. When the silence reaches gap_ticks the frame closes: with a zero
// CRC its bytes are sent on the output channel (out_valid/out_ready) as
// frame_byte with last_of_frame on the final byte, one per cycle while the
// receiver is ready, after a fetch from the frame store; a bad frame is
// dropped silently.
// in_ready is low while the CRC unit runs and while a frame is sent.
// The output register holds its request until taken; a stalled receiver
// holds the flush and thereby the input channel.
// gap_ticks is written through cfg_we/cfg_wdata; the user must write it only while the block is idle (not enforced).
// Reset: synchronous, clears the frame state, gap_ticks returns to 35.
// ----------------------------------------------------------------------------
module rtu_frame_gap_receiver #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        last_of_frame
);
  import rfgr_pkg::*;

  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   silence_count, silence_count_next;
  logic          frame_open, frame_open_next;
  logic [AW-1:0] idx, idx_next;
  logic [15:0]   gap_ticks;

  crc_ctrl_t     crc_ctrl;
  crc_stat_t     crc_stat;
  logic [15:0]   crc_value;

  logic          mem_we;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          load_out;
  logic          is_last;
  logic [15:0]   silence_inc;

  rfgr_crc_unit u_crc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (crc_ctrl),
    .stat      (crc_stat),
    .crc_value (crc_value)
  );

  rfgr_frame_store #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (rx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // gap register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= GAP_RESET;
    end else if (cfg_we) begin
      gap_ticks <= cfg_wdata;
    end
  end

  // state and frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      silence_count <= '0;
      frame_open    <= 1'b0;
      idx           <= '0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      silence_count <= silence_count_next;
      frame_open    <= frame_open_next;
      idx           <= idx_next;
    end
  end

  assign is_last     = ((CW'(idx) + CW'(1)) == byte_count);
  assign silence_inc = (silence_count == SILENCE_MAX) ? silence_count
                                                      : silence_count + 16'd1;
  assign in_ready    = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    silence_count_next = silence_count;
    frame_open_next    = frame_open;
    idx_next           = idx;
    crc_ctrl           = '0;
    mem_we             = 1'b0;
    rd_addr            = idx;
    load_out           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_BYTE) begin
            if (byte_count < DEPTH_C) begin
              mem_we             = 1'b1;
              byte_count_next    = byte_count + CW'(1);
              crc_ctrl.start     = 1'b1;
              crc_ctrl.restart   = !frame_open;
              crc_ctrl.data      = rx_byte;
              frame_open_next    = 1'b1;
              silence_count_next = '0;
              state_next         = S_CRC;
            end
          end else if (frame_open) begin
            if (silence_inc >= gap_ticks) begin
              silence_count_next = '0;
              frame_open_next    = 1'b0;
              if (crc_value == CRC_ZERO) begin
                idx_next   = '0;
                state_next = S_FETCH;
              end else begin
                byte_count_next = '0;
              end
            end else begin
              silence_count_next = silence_inc;
            end
          end
        end
      end
      S_CRC: begin
        if (crc_stat.done) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          if (is_last) begin
            byte_count_next = '0;
            state_next      = S_IDLE;
          end else begin
            idx_next = idx + AW'(1);
            rd_addr  = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame_byte    <= rd_data;
      last_of_frame <= is_last;
    end
  end

endmodule

// ----- dv/rtu_frame_gap_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// rtu_frame_gap_receiver_tb
// Self-checking bench for the RTU frame gap receiver. A short stimulus table
// is walked first. Random phases of CRC-correct frames, corrupted frames and
// line noise follow, each under its own gap setting, then overflowing frames,
// with random idle cycles on both channels. Every accepted request runs
// through a local model of the receiver, and each released frame byte is
// compared field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module rtu_frame_gap_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfgr_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAME_DEPTH = 64;
  localparam int SETTLE      = 16;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_MAX   = 20000;
  localparam int LIMIT_NS    = 10_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last_flag;
  } frame_out_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_GAP
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        zero_typed;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        mode      = MODE_TICK;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_of_frame;

  // local copy of the receiver state
  logic [7:0]  mdl_store [FRAME_DEPTH];
  int          mdl_count   = 0;
  logic [15:0] mdl_crc     = CRC_INIT;
  logic [15:0] mdl_silence = '0;
  logic        mdl_open    = 1'b0;
  logic [15:0] mdl_gap     = GAP_RESET;

  frame_out_t expected_frame_bytes [$];

  int fail_count    = 0;
  int live_reqs     = 0;
  int dropped_bytes = 0;
  int good_frames   = 0;
  int bad_frames    = 0;
  int bytes_checked = 0;
  bit tx_burst      = 1'b0;
  bit rx_fast       = 1'b0;
  bit hold_done     = 1'b0;

  dir_row_t directed_rows [27];

  rtu_frame_gap_receiver #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .last_of_frame(last_of_frame)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // modbus crc-16 over one byte, lsb first
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advance the receiver model by one accepted request
  function automatic void rtu_model_step(input logic m, input logic [7:0] d,
                                         input bit zero_typed);
    frame_out_t r;
    if (m == MODE_BYTE) begin
      if (mdl_count >= FRAME_DEPTH) begin
        dropped_bytes++;
        return;
      end
      mdl_store[mdl_count] = d;
      mdl_count++;
      if (!mdl_open) begin
        mdl_crc  = CRC_INIT;
        mdl_open = 1'b1;
      end
      mdl_crc     = crc16_fold(mdl_crc, d);
      mdl_silence = '0;
      live_reqs++;
      return;
    end
    // ticks while idle are ignored
    if (!mdl_open) return;
    live_reqs++;
    if (mdl_silence != SILENCE_MAX) mdl_silence++;
    if (mdl_silence < mdl_gap) return;
    // frame closes: release it only with a zero residue
    if (mdl_crc == CRC_ZERO) begin
      good_frames++;
      if (!zero_typed) begin
        for (int i = 0; i < mdl_count; i++) begin
          r.data      = mdl_store[i];
          r.last_flag = (i == mdl_count - 1);
          expected_frame_bytes.push_back(r);
        end
      end
    end else begin
      bad_frames++;
    end
    mdl_count   = 0;
    mdl_silence = '0;
    mdl_open    = 1'b0;
  endfunction

  // offer one request and wait for the handshake
  task automatic send_req(input logic m, input logic [7:0] d, input bit zero_typed);
    int idle_n;
    idle_n = tx_burst ? 0 : $urandom_range(0, 9);
    if (idle_n > 0) begin
      in_valid <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    rtu_model_step(m, d, zero_typed);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(MODE_TICK, 8'($urandom), 1'b0);
  endtask

  // enough silence to end the open frame, sometimes a few idle ticks more
  task automatic close_frame();
    send_ticks((mdl_gap == 0) ? 1 : int'(mdl_gap));
    if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 2));
  endtask

  // gap register is only touched once the block has gone quiet
  task automatic write_gap(input logic [15:0] v);
    in_valid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    mdl_gap  = v;
  endtask

  // body bytes plus their crc, optionally hit by one bit error or trailed
  // by bytes past the end of the frame store
  task automatic send_frame(input int body_n, input bit corrupt, input int extra_n);
    logic [7:0]  bytes_q [$];
    logic [15:0] c;
    int          pos;
    int          short_n;
    c = CRC_INIT;
    for (int i = 0; i < body_n; i++) begin
      bytes_q.push_back(8'($urandom));
      c = crc16_fold(c, bytes_q[i]);
    end
    bytes_q.push_back(c[7:0]);
    bytes_q.push_back(c[15:8]);
    if (corrupt) begin
      pos = $urandom_range(0, bytes_q.size() - 1);
      bytes_q[pos] = bytes_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    repeat (extra_n) bytes_q.push_back(8'($urandom));
    short_n = (mdl_gap > 9) ? 8 : int'(mdl_gap) - 1;
    foreach (bytes_q[i]) begin
      send_req(MODE_BYTE, bytes_q[i], 1'b0);
      // silence shorter than the gap keeps the frame open
      if (short_n > 0 && $urandom_range(0, 7) == 0) send_ticks($urandom_range(1, short_n));
    end
    close_frame();
  endtask

  // random mix of bytes and ticks, then a close
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_req(logic'($urandom_range(0, 1)), 8'($urandom), 1'b0);
    close_frame();
  endtask

  task automatic random_phase(input logic [15:0] g, input int quota);
    int start_n;
    int pick;
    write_gap(g);
    start_n = live_reqs;
    while (live_reqs - start_n < quota) begin
      pick     = $urandom_range(0, 9);
      tx_burst = (pick == 9);
      case (pick)
        6: begin
          send_frame($urandom_range(0, 8), 1'b1, 0);
        end
        7: begin
          send_ticks($urandom_range(1, 3));
        end
        8: begin
          send_noise();
        end
        default: begin
          send_frame($urandom_range(0, 8), 1'b0, 0);
        end
      endcase
      tx_burst = 1'b0;
    end
  endtask

  // output side: random stalls, one long hold-off, compare with prediction
  initial begin : frame_byte_check
    int stall_n;
    frame_out_t want;
    while (rst) @(posedge clk);
    forever begin
      stall_n = rx_fast ? 0 : $urandom_range(0, 9);
      if (!hold_done && bytes_checked >= HOLD_AT) begin
        stall_n   = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_n > 0) begin
        out_ready <= 1'b0;
        repeat (stall_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      bytes_checked++;
      if (expected_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %h, last_of_frame %b", frame_byte, last_of_frame);
        fail_count++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected %h, actual %h", want.data, frame_byte);
          fail_count++;
        end
        if (last_of_frame !== want.last_flag) begin
          $error("last_of_frame: expected %b, actual %b", want.last_flag, last_of_frame);
          fail_count++;
        end
      end
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
    end
  end

  // hard stop
  initial begin : run_limit
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int drain_n;
    directed_rows = '{
      '{ROW_TICK, 16'h0000, 1'b1},  // tick right after reset, idle
      '{ROW_GAP,  16'd1,    1'b0},
      '{ROW_BYTE, 16'h0001, 1'b1},  // read holding register request
      '{ROW_BYTE, 16'h0003, 1'b1},
      '{ROW_BYTE, 16'h0000, 1'b1},
      '{ROW_BYTE, 16'h0000, 1'b1},
      '{ROW_BYTE, 16'h0000, 1'b1},
      '{ROW_BYTE, 16'h0001, 1'b1},
      '{ROW_BYTE, 16'h0084, 1'b1},
      '{ROW_BYTE, 16'h000A, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b0},  // gap reached, frame released
      '{ROW_TICK, 16'h0000, 1'b1},  // idle again
      '{ROW_BYTE, 16'h00FF, 1'b1},
      '{ROW_BYTE, 16'h0000, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b0},  // crc residue nonzero, dropped
      '{ROW_GAP,  16'd0,    1'b0},
      '{ROW_BYTE, 16'h00FF, 1'b1},  // crc of an empty body
      '{ROW_BYTE, 16'h00FF, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b0},  // zero gap ends on first tick
      '{ROW_BYTE, 16'h0080, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b0},
      '{ROW_GAP,  16'd2,    1'b0},
      '{ROW_BYTE, 16'h007F, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b1},  // silence below gap
      '{ROW_BYTE, 16'h0001, 1'b1},  // byte clears silence
      '{ROW_TICK, 16'h0000, 1'b1},
      '{ROW_TICK, 16'h0000, 1'b0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_GAP: begin
          write_gap(directed_rows[i].value);
        end
        ROW_BYTE: begin
          send_req(MODE_BYTE, directed_rows[i].value[7:0], directed_rows[i].zero_typed);
        end
        default: begin
          send_req(MODE_TICK, 8'($urandom), directed_rows[i].zero_typed);
        end
      endcase
    end

    // random phases under several gap settings
    random_phase(16'd2, 15);
    random_phase(16'd0, 15);
    random_phase(16'd3, 15);
    random_phase(16'd1, 15);
    random_phase(GAP_RESET, 15);
    random_phase(16'($urandom_range(4, 10)), 15);

    // frame store extremes: full store with bytes dropped past the end,
    // crc bytes lost
    write_gap(16'd1);
    send_frame(FRAME_DEPTH - 2, 1'b0, 3);
    send_frame(FRAME_DEPTH, 1'b0, 0);

    // largest gap: silence far below it keeps the frame open, then a
    // short gap ends it on the next tick
    write_gap(SILENCE_MAX);
    tx_burst = 1'b1;
    send_req(MODE_BYTE, 8'hFF, 1'b0);
    send_req(MODE_BYTE, 8'hFF, 1'b0);
    send_ticks(20);
    tx_burst = 1'b0;
    write_gap(16'd1);
    send_ticks(1);

    // drain
    in_valid <= 1'b0;
    drain_n = 0;
    while (expected_frame_bytes.size() != 0 && drain_n < DRAIN_MAX) begin
      @(posedge clk);
      drain_n++;
    end
    if (expected_frame_bytes.size() != 0) begin
      $error("%0d predicted frame bytes never released", expected_frame_bytes.size());
      fail_count++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("requests %0d (plus %0d bytes past a full store), frames %0d good / %0d bad",
             live_reqs, dropped_bytes, good_frames, bad_frames);
    $display("frame bytes checked %0d, gap settings from 0 to 65535, one long output stall",
             bytes_checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rfgr_pkg.sv
rtl/core/rfgr_crc_unit.sv
rtl/core/rfgr_frame_store.sv
rtl/core/rtu_frame_gap_receiver.sv
dv/rtu_frame_gap_receiver_tb.sv
